// File: src/ctl_pkg.sv
// config token lexer package: field structs, codes, character classes and
// the number recognizer transition function
// no dependencies
package ctl_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int MAX_RES      = 3;
    localparam int RES_CNT_W    = 2;

    // scan modes
    localparam logic [1:0] M_BETWEEN = 2'd0;
    localparam logic [1:0] M_WORD    = 2'd1;
    localparam logic [1:0] M_STRING  = 2'd2;
    localparam logic [1:0] M_ESCAPE  = 2'd3;

    // token types
    localparam logic [3:0] T_IDENT   = 4'd0;
    localparam logic [3:0] T_STRING  = 4'd1;
    localparam logic [3:0] T_INTEGER = 4'd2;
    localparam logic [3:0] T_DECIMAL = 4'd3;
    localparam logic [3:0] T_PLUS    = 4'd4;
    localparam logic [3:0] T_LBRACE  = 4'd5;
    localparam logic [3:0] T_RBRACE  = 4'd6;
    localparam logic [3:0] T_NEWLINE = 4'd7;
    localparam logic [3:0] T_END     = 4'd8;

    // number recognizer states
    localparam logic [4:0] S_START    = 5'd0;
    localparam logic [4:0] S_SIGN     = 5'd1;
    localparam logic [4:0] S_INT      = 5'd2;
    localparam logic [4:0] S_ZERO     = 5'd3;
    localparam logic [4:0] S_DOT0     = 5'd4;
    localparam logic [4:0] S_FRAC     = 5'd5;
    localparam logic [4:0] S_EXP      = 5'd6;
    localparam logic [4:0] S_EXPS     = 5'd7;
    localparam logic [4:0] S_EXPD     = 5'd8;
    localparam logic [4:0] S_HX0      = 5'd9;
    localparam logic [4:0] S_HXD      = 5'd10;
    localparam logic [4:0] S_HXDOT0   = 5'd11;
    localparam logic [4:0] S_HXFRAC   = 5'd12;
    localparam logic [4:0] S_HP       = 5'd13;
    localparam logic [4:0] S_HPS      = 5'd14;
    localparam logic [4:0] S_HPD      = 5'd15;
    localparam logic [4:0] S_I        = 5'd16;
    localparam logic [4:0] S_IN       = 5'd17;
    localparam logic [4:0] S_INF      = 5'd18;
    localparam logic [4:0] S_INFI     = 5'd19;
    localparam logic [4:0] S_INFIN    = 5'd20;
    localparam logic [4:0] S_INFINI   = 5'd21;
    localparam logic [4:0] S_INFINIT  = 5'd22;
    localparam logic [4:0] S_INFINITY = 5'd23;
    localparam logic [4:0] S_N        = 5'd24;
    localparam logic [4:0] S_NA       = 5'd25;
    localparam logic [4:0] S_NAN      = 5'd26;
    localparam logic [4:0] S_NANP     = 5'd27;
    localparam logic [4:0] S_NANC     = 5'd28;
    localparam logic [4:0] S_DEAD     = 5'd29;

    // characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_LBR   = 8'h7b;
    localparam logic [7:0] CH_RBR   = 8'h7d;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LN    = 8'h6e;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LR    = 8'h72;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       at_end;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
        logic [3:0] token_type;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic       last;
    } out_item_t;

    // one result before position is attached
    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
        logic [3:0] token_type;
    } res_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction
    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction
    function automatic logic is_sign(input logic [7:0] c);
        return c == CH_PLUS || c == CH_DASH;
    endfunction
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    // letters of "infinity" after the first, indexed by state offset
    function automatic logic [7:0] inf_char(input logic [4:0] s);
        logic [7:0] r;
        r = 8'h00;
        case (s)
            S_I:       r = 8'h6e;
            S_IN:      r = 8'h66;
            S_INF:     r = 8'h69;
            S_INFI:    r = 8'h6e;
            S_INFIN:   r = 8'h69;
            S_INFINI:  r = 8'h74;
            S_INFINIT: r = 8'h79;
            default:   r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] start_next(input logic [7:0] c, input logic [7:0] l);
        logic [4:0] r;
        if (c == 8'h30)       r = S_ZERO;
        else if (is_digit(c)) r = S_INT;
        else if (c == 8'h2e)  r = S_DOT0;
        else if (l == 8'h69)  r = S_I;
        else if (l == 8'h6e)  r = S_N;
        else                  r = S_DEAD;
        return r;
    endfunction

    function automatic logic [4:0] int_next(input logic [7:0] c, input logic [7:0] l);
        logic [4:0] r;
        if (is_digit(c))      r = S_INT;
        else if (c == 8'h2e)  r = S_FRAC;
        else if (l == 8'h65)  r = S_EXP;
        else                  r = S_DEAD;
        return r;
    endfunction

    // strtol / strtod full-match recognizer
    function automatic logic [4:0] num_next(input logic [4:0] s, input logic [7:0] c);
        logic [7:0] l;
        logic [4:0] r;
        l = to_lower(c);
        r = S_DEAD;
        case (s)
            S_START:  r = is_sign(c) ? S_SIGN : start_next(c, l);
            S_SIGN:   r = start_next(c, l);
            S_ZERO:   r = (l == 8'h78) ? S_HX0 : int_next(c, l);
            S_INT:    r = int_next(c, l);
            S_DOT0:   r = is_digit(c) ? S_FRAC : S_DEAD;
            S_FRAC:   r = is_digit(c) ? S_FRAC : ((l == 8'h65) ? S_EXP : S_DEAD);
            S_EXP:    r = is_sign(c) ? S_EXPS : (is_digit(c) ? S_EXPD : S_DEAD);
            S_EXPS, S_EXPD: r = is_digit(c) ? S_EXPD : S_DEAD;
            S_HX0:    r = is_hex(c) ? S_HXD : ((c == 8'h2e) ? S_HXDOT0 : S_DEAD);
            S_HXD:
            begin
                if (is_hex(c))       r = S_HXD;
                else if (c == 8'h2e) r = S_HXFRAC;
                else if (l == 8'h70) r = S_HP;
                else                 r = S_DEAD;
            end
            S_HXDOT0: r = is_hex(c) ? S_HXFRAC : S_DEAD;
            S_HXFRAC: r = is_hex(c) ? S_HXFRAC : ((l == 8'h70) ? S_HP : S_DEAD);
            S_HP:     r = is_sign(c) ? S_HPS : (is_digit(c) ? S_HPD : S_DEAD);
            S_HPS, S_HPD: r = is_digit(c) ? S_HPD : S_DEAD;
            S_N:      r = (l == 8'h61) ? S_NA : S_DEAD;
            S_NA:     r = (l == 8'h6e) ? S_NAN : S_DEAD;
            S_NAN:    r = (c == 8'h28) ? S_NANP : S_DEAD;
            S_NANP:
            begin
                if (is_alpha(c) || is_digit(c) || c == 8'h5f) r = S_NANP;
                else if (c == 8'h29)                          r = S_NANC;
                else                                          r = S_DEAD;
            end
            S_I, S_IN, S_INF, S_INFI, S_INFIN, S_INFINI, S_INFINIT:
                r = (l == inf_char(s)) ? s + 5'd1 : S_DEAD;
            default:  r = S_DEAD;
        endcase
        return r;
    endfunction

endpackage

// File: src/ctl_core.sv
// config token lexer core: lexer state and the single-pass step logic that
// turns one input transaction into up to three results
// depends on ctl_pkg
module ctl_core
    import ctl_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  in_item_t            item,
    output res_t [MAX_RES-1:0]  res,
    output logic [RES_CNT_W-1:0] res_cnt,
    output logic [RES_CNT_W-1:0] old_cnt,
    output logic [POS_BITS-1:0] tok_line0,
    output logic [POS_BITS-1:0] tok_col0,
    output logic [POS_BITS-1:0] tok_line,
    output logic [POS_BITS-1:0] tok_col
);

    localparam logic [POS_BITS-1:0] POS_SAT = {{(POS_BITS-1){1'b1}}, 1'b0};
    localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};

    logic [1:0]          mode_reg, mode_next;
    logic [4:0]          ncls_reg, ncls_next;
    logic                ident_reg, ident_next;
    logic [7:0]          first_reg, first_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [POS_BITS-1:0] line_reg, line_next;
    logic [POS_BITS-1:0] col_reg, col_next;
    logic [POS_BITS-1:0] tline_reg, tline_next;
    logic [POS_BITS-1:0] tcol_reg, tcol_next;

    logic [7:0] c;
    logic       fin;
    logic       done;
    logic       eat;
    logic [3:0] cls;

    // word type at token end
    always_comb
    begin
        if (cnt_reg == 2'd1 && first_reg == CH_PLUS)      cls = T_PLUS;
        else if (cnt_reg == 2'd1 && first_reg == CH_LBR)  cls = T_LBRACE;
        else if (cnt_reg == 2'd1 && first_reg == CH_RBR)  cls = T_RBRACE;
        else if (ncls_reg == S_INT || ncls_reg == S_ZERO) cls = T_INTEGER;
        else if (ncls_reg == S_FRAC || ncls_reg == S_EXPD || ncls_reg == S_HXD ||
                 ncls_reg == S_HXFRAC || ncls_reg == S_HPD || ncls_reg == S_INF ||
                 ncls_reg == S_INFINITY || ncls_reg == S_NAN || ncls_reg == S_NANC)
            cls = T_DECIMAL;
        else if (ident_reg) cls = T_IDENT;
        else                cls = T_STRING;
    end

    // step logic
    always_comb
    begin
        c          = item.byte_in;
        fin        = item.at_end;
        mode_next  = mode_reg;
        ncls_next  = ncls_reg;
        ident_next = ident_reg;
        first_next = first_reg;
        cnt_next   = cnt_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        done       = 1'b0;
        eat        = 1'b0;
        res_cnt    = '0;
        old_cnt    = '0;
        res        = '0;

        unique case (mode_reg)
            M_WORD:
            begin
                if (fin || is_blank(c))
                begin
                    res[0]    = '{1'b1, 8'h00, cls};
                    res_cnt   = 2'd1;
                    mode_next = M_BETWEEN;
                end
                else
                begin
                    eat       = 1'b1;
                    ncls_next = num_next(ncls_reg, c);
                    if (!(is_alpha(c) || is_digit(c) || c == CH_DASH))
                        ident_next = 1'b0;
                    if (cnt_reg < 2'd2)
                        cnt_next = cnt_reg + 2'd1;
                    res[0]  = '{1'b0, c, T_IDENT};
                    res_cnt = 2'd1;
                    done    = 1'b1;
                end
            end
            M_STRING:
            begin
                if (fin)
                begin
                    res[0]    = '{1'b1, 8'h00, T_STRING};
                    res_cnt   = 2'd1;
                    mode_next = M_BETWEEN;
                end
                else
                begin
                    eat  = 1'b1;
                    done = 1'b1;
                    if (c == CH_QUOTE)
                    begin
                        res[0]    = '{1'b1, 8'h00, T_STRING};
                        res_cnt   = 2'd1;
                        mode_next = M_BETWEEN;
                    end
                    else if (c == CH_BSL)
                        mode_next = M_ESCAPE;
                    else
                    begin
                        res[0]  = '{1'b0, c, T_IDENT};
                        res_cnt = 2'd1;
                    end
                end
            end
            M_ESCAPE:
            begin
                if (fin)
                begin
                    res[0]    = '{1'b0, CH_BSL, T_IDENT};
                    res[1]    = '{1'b1, 8'h00, T_STRING};
                    res_cnt   = 2'd2;
                    mode_next = M_BETWEEN;
                end
                else
                begin
                    eat       = 1'b1;
                    done      = 1'b1;
                    mode_next = M_STRING;
                    res_cnt   = 2'd1;
                    if (c == CH_LN)      res[0] = '{1'b0, CH_NL, T_IDENT};
                    else if (c == CH_LT) res[0] = '{1'b0, CH_TAB, T_IDENT};
                    else if (c == CH_LR) res[0] = '{1'b0, CH_CR, T_IDENT};
                    else if (c == CH_QUOTE || c == CH_BSL)
                        res[0] = '{1'b0, c, T_IDENT};
                    else
                    begin
                        res[0]  = '{1'b0, CH_BSL, T_IDENT};
                        res[1]  = '{1'b0, c, T_IDENT};
                        res_cnt = 2'd2;
                    end
                end
            end
            default: ;
        endcase

        // results so far carry the start of the token that just closed
        old_cnt = res_cnt;

        // between tokens, also right after a word ended
        if (!done)
        begin
            if (fin)
            begin
                tline_next       = line_reg + POS_ONE;
                tcol_next        = col_reg + POS_ONE;
                res[res_cnt]     = '{1'b1, 8'h00, T_END};
                res_cnt          = res_cnt + 2'd1;
            end
            else if (c == CH_NL)
            begin
                tline_next         = line_reg + POS_ONE;
                tcol_next          = col_reg + POS_ONE;
                res[res_cnt]       = '{1'b0, CH_NL, T_IDENT};
                res[res_cnt+2'd1]  = '{1'b1, 8'h00, T_NEWLINE};
                res_cnt            = res_cnt + 2'd2;
                eat                = 1'b1;
            end
            else if (is_blank(c))
                eat = 1'b1;
            else if (c == CH_QUOTE)
            begin
                tline_next = line_reg + POS_ONE;
                tcol_next  = col_reg + POS_ONE;
                eat        = 1'b1;
                mode_next  = M_STRING;
            end
            else
            begin
                tline_next   = line_reg + POS_ONE;
                tcol_next    = col_reg + POS_ONE;
                eat          = 1'b1;
                first_next   = c;
                cnt_next     = 2'd1;
                ncls_next    = num_next(S_START, c);
                ident_next   = is_alpha(c) || c == CH_DASH;
                mode_next    = M_WORD;
                res[res_cnt] = '{1'b0, c, T_IDENT};
                res_cnt      = res_cnt + 2'd1;
            end
        end

        if (mode_next != M_WORD)
        begin
            ncls_next  = S_START;
            ident_next = 1'b1;
            first_next = 8'h00;
            cnt_next   = 2'd0;
        end
    end

    // saturating position counters
    always_comb
    begin
        line_next = line_reg;
        col_next  = col_reg;
        if (eat)
        begin
            if (c == CH_NL)
            begin
                if (line_reg < POS_SAT)
                    line_next = line_reg + POS_ONE;
                col_next = '0;
            end
            else if (col_reg < POS_SAT)
                col_next = col_reg + POS_ONE;
        end
    end

    // token start before and after this step
    assign tok_line0 = tline_reg;
    assign tok_col0  = tcol_reg;
    assign tok_line  = tline_next;
    assign tok_col   = tcol_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_BETWEEN;
            ncls_reg  <= S_START;
            ident_reg <= 1'b1;
            first_reg <= 8'h00;
            cnt_reg   <= 2'd0;
            line_reg  <= '0;
            col_reg   <= '0;
            tline_reg <= '0;
            tcol_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            ncls_reg  <= ncls_next;
            ident_reg <= ident_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
        end
    end

endmodule

// File: src/ctl_outq.sv
// config token lexer output side: holds the results of one step and hands
// them out one per cycle while not stalled; the next step loads only when
// the group is empty or its last result leaves; depends on ctl_pkg
module ctl_outq
    import ctl_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  res_t [MAX_RES-1:0]   res,
    input  logic [RES_CNT_W-1:0] res_cnt,
    input  logic [RES_CNT_W-1:0] old_cnt,
    input  logic [POS_BITS-1:0]  tok_line0,
    input  logic [POS_BITS-1:0]  tok_col0,
    input  logic [POS_BITS-1:0]  tok_line,
    input  logic [POS_BITS-1:0]  tok_col,
    output logic                 can_load,
    output logic                 valid,
    input  logic                 stall,
    output out_item_t            data
);

    // the group being drained
    res_t [MAX_RES-1:0]   grp_reg;
    logic [RES_CNT_W-1:0] left_reg, left_next;
    logic [RES_CNT_W-1:0] idx_reg, idx_next;
    logic [RES_CNT_W-1:0] old_reg;
    logic [POS_BITS-1:0]  gl0_reg, gc0_reg;
    logic [POS_BITS-1:0]  gl_reg, gc_reg;

    logic take;
    logic last_one;
    logic use_old;

    assign valid    = left_reg != '0;
    assign take     = valid && !stall;
    assign last_one = left_reg == 2'd1;
    // a new group enters when the current one is empty or finishing now
    assign can_load = !valid || (take && last_one);
    // leading results belong to the token that closed in this step
    assign use_old  = idx_reg < old_reg;

    always_comb
    begin
        left_next = left_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            left_next = left_reg - 2'd1;
            idx_next  = idx_reg + 2'd1;
        end
        if (load)
        begin
            left_next = res_cnt;
            idx_next  = '0;
        end
    end

    always_comb
    begin
        data.kind         = grp_reg[idx_reg].kind;
        data.text_byte    = grp_reg[idx_reg].text_byte;
        data.token_type   = grp_reg[idx_reg].kind ? grp_reg[idx_reg].token_type : T_IDENT;
        data.start_line   = use_old ? 16'(gl0_reg) : 16'(gl_reg);
        data.start_column = use_old ? 16'(gc0_reg) : 16'(gc_reg);
        data.last         = last_one;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            left_reg <= left_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= res;
            old_reg <= old_cnt;
            gl0_reg <= tok_line0;
            gc0_reg <= tok_col0;
            gl_reg  <= tok_line;
            gc_reg  <= tok_col;
        end
    end

endmodule

// File: src/config_token_lexer.sv
// config token lexer top level: input handshake, step core and result queue
// depends on ctl_pkg, ctl_core, ctl_outq
//
//  channel  direction  handshake       payload
//  in       input      in_valid/stall  in_item_t (byte_in, at_end)
//  out      output     valid/stall     out_item_t (kind .. last)
//
// each accepted transaction is processed in the cycle it is accepted; its
// zero to three results are registered and leave one per cycle from the
// following cycle while the output is not stalled. a new transaction
// enters only when the queue is empty or as the last result of the
// previous one is taken. reset clears lexer state and empties the result
// queue. an output stall holds the queue and backs up the input.
module config_token_lexer
    import ctl_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    res_t [MAX_RES-1:0]   res;
    logic [RES_CNT_W-1:0] res_cnt;
    logic [RES_CNT_W-1:0] old_cnt;
    logic [POS_BITS-1:0]  tok_line0;
    logic [POS_BITS-1:0]  tok_col0;
    logic [POS_BITS-1:0]  tok_line;
    logic [POS_BITS-1:0]  tok_col;
    logic                 can_load;
    logic                 step;

    assign in_stall = !can_load;
    assign step     = in_valid && can_load;

    ctl_core #(.POS_BITS(POS_BITS)) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_data),
        .res       (res),
        .res_cnt   (res_cnt),
        .old_cnt   (old_cnt),
        .tok_line0 (tok_line0),
        .tok_col0  (tok_col0),
        .tok_line  (tok_line),
        .tok_col   (tok_col)
    );

    ctl_outq #(.POS_BITS(POS_BITS)) u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res       (res),
        .res_cnt   (res_cnt),
        .old_cnt   (old_cnt),
        .tok_line0 (tok_line0),
        .tok_col0  (tok_col0),
        .tok_line  (tok_line),
        .tok_col   (tok_col),
        .can_load  (can_load),
        .valid     (out_valid),
        .stall     (out_stall),
        .data      (out_data)
    );

endmodule

// File: src/ctl_checks.sv
// config token lexer port checker and its bind to the top level
// depends on ctl_pkg
module ctl_checks
    import ctl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // input is back-pressured only while results are pending
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty queue");

    // a completion carries a valid token type
    a_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind |-> out_data.token_type <= T_END)
        else $error("bad token type");

    // start lines of completions are one based
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind |-> out_data.start_line != 16'd0)
        else $error("zero start line");

endmodule

bind config_token_lexer ctl_checks u_checks
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: tb/ctl_checker.sv
// lexer result checker: predicts each accepted transaction's results and
// compares them against the output channel; depends on ctl_pkg
module ctl_checker
    import ctl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending
);

    localparam logic [15:0] POS_SAT = 16'hfffe;

    // lexer state mirror
    logic [1:0]  mode;
    logic [4:0]  numst;
    logic        word_ok;
    logic [7:0]  lead;
    logic [1:0]  nchars;
    logic [15:0] line_n, col_n, tok_line, tok_col;

    out_item_t expected_results[$];

    function automatic logic blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic hexd(input logic [7:0] c);
        return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction
    function automatic logic sign(input logic [7:0] c);
        return c == CH_PLUS || c == CH_DASH;
    endfunction

    // strtol/strtod full-match recognizer
    function automatic logic [4:0] number_step(input logic [4:0] s, input logic [7:0] c);
        logic [7:0] l;
        logic [4:0] r;
        string      word;
        word = "infinity";
        l = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        r = S_DEAD;
        if (s == S_START && sign(c)) r = S_SIGN;
        else if (s == S_START || s == S_SIGN)
        begin
            if (c == "0") r = S_ZERO;
            else if (digit(c)) r = S_INT;
            else if (c == ".") r = S_DOT0;
            else if (l == "i") r = S_I;
            else if (l == "n") r = S_N;
        end
        else if (s == S_ZERO && l == "x") r = S_HX0;
        else if (s == S_ZERO || s == S_INT)
        begin
            if (digit(c)) r = S_INT;
            else if (c == ".") r = S_FRAC;
            else if (l == "e") r = S_EXP;
        end
        else if (s == S_DOT0) r = digit(c) ? S_FRAC : S_DEAD;
        else if (s == S_FRAC) r = digit(c) ? S_FRAC : (l == "e" ? S_EXP : S_DEAD);
        else if (s == S_EXP && sign(c)) r = S_EXPS;
        else if (s == S_EXP || s == S_EXPS || s == S_EXPD) r = digit(c) ? S_EXPD : S_DEAD;
        else if (s == S_HX0) r = hexd(c) ? S_HXD : (c == "." ? S_HXDOT0 : S_DEAD);
        else if (s == S_HXD)
        begin
            if (hexd(c)) r = S_HXD;
            else if (c == ".") r = S_HXFRAC;
            else if (l == "p") r = S_HP;
        end
        else if (s == S_HXDOT0) r = hexd(c) ? S_HXFRAC : S_DEAD;
        else if (s == S_HXFRAC) r = hexd(c) ? S_HXFRAC : (l == "p" ? S_HP : S_DEAD);
        else if (s == S_HP && sign(c)) r = S_HPS;
        else if (s == S_HP || s == S_HPS || s == S_HPD) r = digit(c) ? S_HPD : S_DEAD;
        else if (s == S_N) r = (l == "a") ? S_NA : S_DEAD;
        else if (s == S_NA) r = (l == "n") ? S_NAN : S_DEAD;
        else if (s == S_NAN) r = (c == "(") ? S_NANP : S_DEAD;
        else if (s == S_NANP)
        begin
            if (alpha(c) || digit(c) || c == "_") r = S_NANP;
            else if (c == ")") r = S_NANC;
        end
        else if (s >= S_I && s < S_INFINITY)
            r = (l == word[s - S_I + 1]) ? s + 5'd1 : S_DEAD;
        return r;
    endfunction

    function automatic logic [3:0] word_type();
        if (nchars == 2'd1 && lead == CH_PLUS) return T_PLUS;
        if (nchars == 2'd1 && lead == CH_LBR) return T_LBRACE;
        if (nchars == 2'd1 && lead == CH_RBR) return T_RBRACE;
        if (numst == S_INT || numst == S_ZERO) return T_INTEGER;
        if (numst == S_FRAC || numst == S_EXPD || numst == S_HXD || numst == S_HXFRAC ||
            numst == S_HPD || numst == S_INF || numst == S_INFINITY || numst == S_NAN ||
            numst == S_NANC)
            return T_DECIMAL;
        return word_ok ? T_IDENT : T_STRING;
    endfunction

    task automatic advance_pos(input logic [7:0] c);
        if (c == CH_NL)
        begin
            if (line_n < POS_SAT) line_n = line_n + 16'd1;
            col_n = '0;
        end
        else if (col_n < POS_SAT) col_n = col_n + 16'd1;
    endtask

    task automatic push_result(inout out_item_t batch[$], input logic k,
                               input logic [7:0] b, input logic [3:0] t);
        out_item_t r;
        r.kind = k;
        r.text_byte = b;
        r.token_type = t;
        r.start_line = tok_line;
        r.start_column = tok_col;
        r.last = 1'b0;
        batch.push_back(r);
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic fin);
        out_item_t batch[$];
        logic      handled;
        handled = 1'b0;
        if (mode == M_WORD)
        begin
            if (fin || blank(c))
            begin
                push_result(batch, 1'b1, 8'd0, word_type());
                mode = M_BETWEEN;
            end
            else
            begin
                advance_pos(c);
                numst = number_step(numst, c);
                if (!(alpha(c) || digit(c) || c == CH_DASH)) word_ok = 1'b0;
                if (nchars < 2'd2) nchars = nchars + 2'd1;
                push_result(batch, 1'b0, c, T_IDENT);
                handled = 1'b1;
            end
        end
        else if (mode == M_STRING)
        begin
            if (fin)
            begin
                push_result(batch, 1'b1, 8'd0, T_STRING);
                mode = M_BETWEEN;
            end
            else
            begin
                advance_pos(c);
                if (c == CH_QUOTE)
                begin
                    push_result(batch, 1'b1, 8'd0, T_STRING);
                    mode = M_BETWEEN;
                end
                else if (c == CH_BSL) mode = M_ESCAPE;
                else push_result(batch, 1'b0, c, T_IDENT);
                handled = 1'b1;
            end
        end
        else if (mode == M_ESCAPE)
        begin
            if (fin)
            begin
                push_result(batch, 1'b0, CH_BSL, T_IDENT);
                push_result(batch, 1'b1, 8'd0, T_STRING);
                mode = M_BETWEEN;
            end
            else
            begin
                advance_pos(c);
                if (c == CH_LN) push_result(batch, 1'b0, CH_NL, T_IDENT);
                else if (c == CH_LT) push_result(batch, 1'b0, CH_TAB, T_IDENT);
                else if (c == CH_LR) push_result(batch, 1'b0, CH_CR, T_IDENT);
                else if (c == CH_QUOTE || c == CH_BSL) push_result(batch, 1'b0, c, T_IDENT);
                else
                begin
                    push_result(batch, 1'b0, CH_BSL, T_IDENT);
                    push_result(batch, 1'b0, c, T_IDENT);
                end
                mode = M_STRING;
                handled = 1'b1;
            end
        end
        // between tokens, or a word just closed
        if (!handled)
        begin
            if (fin)
            begin
                tok_line = line_n + 16'd1;
                tok_col = col_n + 16'd1;
                push_result(batch, 1'b1, 8'd0, T_END);
            end
            else if (c == CH_NL)
            begin
                tok_line = line_n + 16'd1;
                tok_col = col_n + 16'd1;
                push_result(batch, 1'b0, CH_NL, T_IDENT);
                push_result(batch, 1'b1, 8'd0, T_NEWLINE);
                advance_pos(c);
            end
            else if (blank(c)) advance_pos(c);
            else
            begin
                tok_line = line_n + 16'd1;
                tok_col = col_n + 16'd1;
                advance_pos(c);
                if (c == CH_QUOTE) mode = M_STRING;
                else
                begin
                    lead = c;
                    nchars = 2'd1;
                    numst = number_step(S_START, c);
                    word_ok = alpha(c) || c == CH_DASH;
                    mode = M_WORD;
                    push_result(batch, 1'b0, c, T_IDENT);
                end
            end
        end
        if (mode != M_WORD)
        begin
            numst = S_START;
            word_ok = 1'b1;
            lead = '0;
            nchars = '0;
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) expected_results.push_back(batch[i]);
    endtask

    // predict on input transactions, compare on output transactions
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            mode = M_BETWEEN;
            numst = S_START;
            word_ok = 1'b1;
            lead = '0;
            nchars = '0;
            line_n = '0;
            col_n = '0;
            tok_line = '0;
            tok_col = '0;
            fail_count = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction %p", out_data);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_data.kind !== e.kind)
                        begin $error("kind exp %0d got %0d", e.kind, out_data.kind); fail_count++; end
                    if (out_data.text_byte !== e.text_byte)
                        begin $error("text_byte exp %0h got %0h", e.text_byte, out_data.text_byte); fail_count++; end
                    if (out_data.token_type !== e.token_type)
                        begin $error("token_type exp %0d got %0d", e.token_type, out_data.token_type); fail_count++; end
                    if (out_data.start_line !== e.start_line)
                        begin $error("start_line exp %0d got %0d", e.start_line, out_data.start_line); fail_count++; end
                    if (out_data.start_column !== e.start_column)
                        begin $error("start_column exp %0d got %0d", e.start_column, out_data.start_column); fail_count++; end
                    if (out_data.last !== e.last)
                        begin $error("last exp %0d got %0d", e.last, out_data.last); fail_count++; end
                end
            end
            if (in_valid && !in_stall) lex_byte(in_data.byte_in, in_data.at_end);
            pending = expected_results.size();
        end
    end

endmodule

// File: tb/tb_config_token_lexer.sv
// lexer testbench top: clock, reset, directed and random character stream,
// output stalls and verdict; depends on ctl_pkg, ctl_checker, config_token_lexer
module tb_config_token_lexer;
    import ctl_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    int        fail_count;
    int        pending;
    logic      calm;
    int        sent;

    config_token_lexer DUT (.*);

    ctl_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver stall bursts
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 18);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat (n) @(posedge clk);
        end
    end

    // one transaction, with a possible idle burst before it
    task automatic send(input logic [7:0] c, input logic fin);
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.byte_in <= c;
        in_data.at_end <= fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_char();
        string pool;
        int    r;
        pool = "aZx-09+.eEpPinfnay(_)\"\\{}ntr \t\n";
        r = $urandom_range(0, 9);
        if (r == 0) return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    initial
    begin
        string words[$];
        int    k;
        words = '{"12", "-0", "0x1F.ap-3", "1.5e+7", "inf", "INFINITY", "nan(a_1)",
                  "nan", "ab-9", "+", "{", "}", ".5", "0x", "1e", "x$y", "\"a\\nb\\q\"",
                  "\"\\t\\r\\\"\\\\\"", "-", "++", "infin"};
        calm = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, escapes, number forms, end inside string
        send_text("ab-9 +{} 0x1F.ap-3 \n1.5e+7 inf nan(a_1)\t\"x\\n\\q\\\n\"");
        send(8'h00, 1'b0);
        send(8'hff, 1'b0);
        send(8'h20, 1'b0);
        send_text("\"ab\\");
        send(8'hff, 1'b1);
        send_text("\"open");
        send(8'h00, 1'b1);
        send(8'h00, 1'b1);
        // hold off until drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // random: mostly well-formed words, some noise
        while (sent < 320)
        begin
            if (sent > 260) calm = 1'b1;
            k = $urandom_range(0, 9);
            if (k < 6) send_text(words[$urandom_range(0, words.size() - 1)]);
            else if (k < 9) repeat ($urandom_range(1, 6)) send(pick_char(), 1'b0);
            else send(8'($urandom), 1'b1);
            send(($urandom_range(0, 3) == 0) ? CH_NL : 8'h20, 1'b0);
        end
        // a long word to finish
        repeat (40) send(8'h61, 1'b0);
        send(8'h00, 1'b1);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
